FILE: hw/rtl/iee_pkg.sv
`default_nettype none
package iee_pkg;

	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_MUL,
		CLS_DIV,
		CLS_ADD,
		CLS_SUB,
		CLS_EQUAL
	} char_class_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_MUL   = 2'd1,
		OP_DIV   = 2'd2
	} pend_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN,
		ST_OUT
	} exec_state_t;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	localparam int OUT_WIDTH = 32;

	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
	} token_t;

endpackage
`default_nettype wire

FILE: hw/rtl/iee_front.sv
`default_nettype none
module iee_front import iee_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] char_code,
	output logic            tok_valid,
	input  wire logic       tok_stall,
	output token_t          tok
);
	// Two-entry queue of classified characters.
	token_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       keep;
	token_t     cls_tok;
	logic       push, pop;

	always_comb begin
		keep = 1'b1;
		cls_tok.digit = 4'(char_code - CH_ZERO);
		cls_tok.cls = CLS_DIGIT;
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			cls_tok.cls = CLS_DIGIT;
		end else begin
			case (char_code)
				CH_STAR:  cls_tok.cls = CLS_MUL;
				CH_SLASH: cls_tok.cls = CLS_DIV;
				CH_PLUS:  cls_tok.cls = CLS_ADD;
				CH_MINUS: cls_tok.cls = CLS_SUB;
				CH_EQUAL: cls_tok.cls = CLS_EQUAL;
				default:  keep = 1'b0;
			endcase
		end
	end

	assign in_stall  = (cnt_q == 2'd2);
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = mem_q[rd_q];
	assign push      = in_valid && !in_stall && keep;
	assign pop       = tok_valid && !tok_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cls_tok;
	end
endmodule
`default_nettype wire

FILE: hw/rtl/iee_exec.sv
`default_nettype none
module iee_exec import iee_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  tok_valid,
	output logic                       tok_stall,
	input  token_t                     tok,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic signed [OUT_WIDTH-1:0] value,
	output logic                       divide_by_zero
);
	localparam int W  = VALUE_WIDTH;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0] sum_q, term_q, num_q;
	pend_op_t     pend_q;
	logic         neg_q, dz_q;
	exec_state_t  state_q;
	char_class_t  cls_q;

	// Shared shift unit for multiply and divide.
	logic [W-1:0] acc_q, opa_q, opb_q;
	logic [W:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic         qneg_q;

	logic [W-1:0] nx_term;
	logic [W:0]   rem_sh, rem_sub;
	logic [W-1:0] num_close;
	logic         close_now;

	// Value of the open term after the current number is folded in, for the
	// cases that need no shift unit.
	always_comb begin
		num_close = neg_q ? (W'(0) - num_q) : num_q;
		close_now = (pend_q != OP_MUL) && (pend_q != OP_DIV);
		nx_term   = num_close;
		rem_sh    = {rem_q[W-1:0], opa_q[W-1]};
		rem_sub   = rem_sh - {1'b0, opb_q};
	end

	assign tok_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			sum_q     <= '0;
			term_q    <= '0;
			num_q     <= '0;
			pend_q    <= OP_START;
			neg_q     <= 1'b0;
			dz_q      <= 1'b0;
			out_valid <= 1'b0;
			cls_q     <= CLS_DIGIT;
			cnt_q     <= '0;
			acc_q     <= '0;
			opa_q     <= '0;
			opb_q     <= '0;
			rem_q     <= '0;
			qneg_q    <= 1'b0;
			value     <= '0;
			divide_by_zero <= 1'b0;
		end else begin
			if (state_q == ST_FIN && cls_q == CLS_EQUAL && (!out_valid || !out_stall))
				out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (tok_valid) begin
						cls_q <= tok.cls;
						if (tok.cls == CLS_DIGIT) begin
							num_q <= W'(num_q * W'(10)) + W'(tok.digit);
						end else if (pend_q == OP_MUL) begin
							acc_q <= '0;
							opa_q <= term_q;
							opb_q <= num_q;
							cnt_q <= CW'(W);
							state_q <= ST_MUL;
						end else if (pend_q == OP_DIV) begin
							if (num_q == '0) begin
								dz_q   <= 1'b1;
								term_q <= '0;
								state_q <= ST_FIN;
							end else begin
								opa_q  <= term_q[W-1] ? W'(0) - term_q : term_q;
								opb_q  <= num_q[W-1] ? W'(0) - num_q : num_q;
								qneg_q <= term_q[W-1] ^ num_q[W-1];
								rem_q  <= '0;
								acc_q  <= '0;
								cnt_q  <= CW'(W);
								state_q <= ST_DIV;
							end
						end else begin
							term_q  <= close_now ? nx_term : term_q;
							state_q <= ST_FIN;
						end
					end
				end
				ST_MUL: begin
					if (opb_q[0]) acc_q <= acc_q + opa_q;
					opa_q <= opa_q << 1;
					opb_q <= opb_q >> 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= ST_OUT;
				end
				ST_DIV: begin
					opa_q <= opa_q << 1;
					if (!rem_sub[W]) begin
						rem_q <= rem_sub;
						acc_q <= {acc_q[W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						acc_q <= {acc_q[W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) state_q <= ST_OUT;
				end
				ST_OUT: begin
					// Result of the shift unit lands in the term.
					if (pend_q == OP_DIV && qneg_q) term_q <= W'(0) - acc_q;
					else term_q <= acc_q;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					num_q <= '0;
					case (cls_q)
						CLS_MUL: begin
							pend_q  <= OP_MUL;
							state_q <= ST_IDLE;
						end
						CLS_DIV: begin
							pend_q  <= OP_DIV;
							state_q <= ST_IDLE;
						end
						CLS_ADD, CLS_SUB: begin
							sum_q   <= sum_q + term_q;
							term_q  <= '0;
							pend_q  <= OP_START;
							neg_q   <= (cls_q == CLS_SUB);
							state_q <= ST_IDLE;
						end
						CLS_EQUAL: begin
							if (!out_valid || !out_stall) begin
								value <= OUT_WIDTH'(signed'(W'(sum_q + term_q)));
								divide_by_zero <= dz_q;
								sum_q  <= '0;
								term_q <= '0;
								pend_q <= OP_START;
								neg_q  <= 1'b0;
								dz_q   <= 1'b0;
								state_q <= ST_IDLE;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: hw/rtl/infix_expression_evaluator.sv
`default_nettype none
// Streaming evaluator for integer infix expressions without parentheses.
// The input channel (in_valid, in_stall, char_code) takes one ASCII
// character per transfer. Digits build a number, + - * / are operators
// with * and / binding tighter, and '=' ends the expression. Any other
// character is dropped on arrival.
// The output channel (out_valid, out_stall, value, divide_by_zero) makes
// one transfer per '=': the 32-bit result and a flag that tells whether a
// division by zero occurred. The expression state then returns to reset.
// A front stage classifies characters into a two-entry queue, so input can
// keep arriving while the back end works. A digit is folded into the
// number in ST_IDLE; an operator also passes through ST_FIN. An operator
// or '=' that closes a number after a pending * or / runs a shared
// shift-add / restoring-divide unit one bit per cycle, through ST_MUL or
// ST_DIV and ST_OUT to ST_FIN; a division by zero skips the unit. out_valid
// is registered with the result as '=' leaves ST_FIN. When the receiver
// stalls, the result is held in the output register and the back end
// waits at the next '='; the queue fills and then in_stall rises. Reset
// (arst_n low) clears the queue, the result register and all expression
// state.
module infix_expression_evaluator import iee_pkg::*; #(
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             char_code,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic signed [OUT_WIDTH-1:0] value,
	output logic                        divide_by_zero
);
	token_t tok;
	logic   tok_valid, tok_stall;

	iee_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.tok_valid (tok_valid),
		.tok_stall (tok_stall),
		.tok       (tok)
	);

	iee_exec #(.VALUE_WIDTH(VALUE_WIDTH)) u_exec (
		.clk            (clk),
		.arst_n         (arst_n),
		.tok_valid      (tok_valid),
		.tok_stall      (tok_stall),
		.tok            (tok),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.value          (value),
		.divide_by_zero (divide_by_zero)
	);
endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
`default_nettype none

// The bench drives ASCII characters into the evaluator and predicts each result itself.
// It keeps a sum, a term, a number, the pending operator and the sign of the term.
// The same prediction runs when a character is accepted.
// Predicted results wait in a queue until the monitor compares them with the block's output.
module tb;
	import iee_pkg::*;

	localparam int MAX_CYCLES = 2_000_000;

	typedef struct {
		logic signed [31:0] value;
		logic               dz;
	} eval_result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_stall;
	logic signed [31:0] value;
	logic        divide_by_zero;

	// These are the characters still waiting to be sent, and the results still expected.
	logic [7:0]   char_queue[$];
	eval_result_t result_queue[$];

	// This is the bench's own copy of the expression state.
	logic [31:0] sum_acc;
	logic [31:0] term_acc;
	logic [31:0] num_acc;
	pend_op_t    pend;
	logic        term_neg;
	logic        dz_seen;

	int errors;
	int results_seen;
	int chars_sent;
	int tx_gap;
	int rx_gap;
	int hold_cycles;

	infix_expression_evaluator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .char_code(char_code),
		.out_valid(out_valid), .out_stall(out_stall),
		.value(value), .divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [31:0] quotient(logic [31:0] n, logic [31:0] d);
		logic signed [32:0] sn;
		logic signed [32:0] sd;
		logic signed [32:0] q;
		sn = $signed({n[31], n});
		sd = $signed({d[31], d});
		q = sn / sd;
		return q[31:0];
	endfunction

	// This finishes the number being typed, according to the pending operator.
	task automatic close_number();
		if (pend == OP_MUL) begin
			term_acc = term_acc * num_acc;
		end else if (pend == OP_DIV) begin
			if (num_acc == 0) begin
				dz_seen = 1'b1;
				term_acc = 0;
			end else begin
				term_acc = quotient(term_acc, num_acc);
			end
		end else begin
			term_acc = term_neg ? -num_acc : num_acc;
		end
		num_acc = 0;
	endtask

	task automatic close_term(bit neg);
		sum_acc = sum_acc + term_acc;
		term_acc = 0;
		pend = OP_START;
		term_neg = neg;
	endtask

	task automatic clear_expression();
		sum_acc = 0;
		term_acc = 0;
		num_acc = 0;
		pend = OP_START;
		term_neg = 0;
		dz_seen = 0;
	endtask

	task automatic evaluate_char(logic [7:0] c);
		eval_result_t r;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			num_acc = num_acc * 10 + 32'(c - CH_ZERO);
		end else if (c == CH_STAR || c == CH_SLASH) begin
			close_number();
			pend = (c == CH_STAR) ? OP_MUL : OP_DIV;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			close_number();
			close_term(c == CH_MINUS);
		end else if (c == CH_EQUAL) begin
			close_number();
			close_term(1'b0);
			r.value = sum_acc;
			r.dz = dz_seen;
			result_queue.push_back(r);
			clear_expression();
		end
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
	endtask

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// The driver moves to the next character after a transfer. It may leave a gap first.
	// While it holds valid, the payload does not change.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			char_code <= 8'h00;
			tx_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				evaluate_char(char_code);
				chars_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (char_queue.size() > 0) begin
					char_code <= char_queue.pop_front();
					in_valid <= 1'b1;
					tx_gap <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// The monitor compares each output transfer with the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (result_queue.size() == 0) begin
				report("unexpected result", value, 32'd0);
			end else begin
				if (value !== result_queue[0].value)
					report("value", value, result_queue[0].value);
				if (divide_by_zero !== result_queue[0].dz)
					report("divide_by_zero", 32'(divide_by_zero),
						32'(result_queue[0].dz));
				void'(result_queue.pop_front());
			end
		end
	end

	// The receiver stalls in gaps of random length.
	// A long hold happens once, early in the run, so that the block fills up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
			rx_gap <= 0;
			hold_cycles <= 400;
		end else if (hold_cycles > 0 && chars_sent > 20) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(0, 3) == 0) rx_gap <= pick_gap();
		end
	end

	task automatic push_str(string s);
		for (int i = 0; i < s.len(); i++) char_queue.push_back(s[i]);
	endtask

	task automatic push_number();
		int p;
		int n;
		p = $urandom_range(0, 9);
		if (p < 2) begin
			push_str("0");
		end else if (p < 8) begin
			push_str($sformatf("%0d", $urandom_range(1, 999)));
		end else if (p < 9) begin
			push_str($sformatf("%0d", $urandom));
		end else begin
			// Long runs of digits wrap modulo 2^32.
			n = $urandom_range(10, 14);
			repeat (n) char_queue.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
	endtask

	task automatic push_expression();
		int terms;
		int k;
		string ops;
		ops = "+-*/";
		terms = $urandom_range(1, 6);
		if ($urandom_range(0, 3) == 0) push_str("-");
		for (int i = 0; i < terms; i++) begin
			if (i > 0) char_queue.push_back(ops[$urandom_range(0, 3)]);
			if ($urandom_range(0, 9) == 0) push_str(" ");
			k = $urandom_range(0, 19);
			// Sometimes the number is left out, or a stray character is added.
			if (k == 0) continue;
			if (k == 1) char_queue.push_back(8'($urandom_range(0, 255)));
			push_number();
		end
		if ($urandom_range(0, 19) == 0) char_queue.push_back(8'($urandom_range(0, 255)));
		push_str("=");
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
		chars_sent = 0;
		clear_expression();
		// The directed part checks the edge cases.
		push_str("=");
		push_str("-5=");
		push_str("2*-3=");
		push_str("-7/2=");
		push_str("7/0+1=");
		push_str("2147483647+1=");
		push_str("0-2147483648/-1=");
		push_str("4294967295*2 =");
		push_str("1+2*3-8/4=");
		char_queue.push_back(8'hFF);
		char_queue.push_back(8'h00);
		push_str("99999999999=");
		while (char_queue.size() < 1900) push_expression();
		// Every bit of char_code takes both values.
		for (int b = 0; b < 8; b++) char_queue.push_back(8'(1 << b) | 8'h80);
		push_str("=");
		wait (char_queue.size() == 0 && !in_valid);
		wait (result_queue.size() == 0);
		repeat (100) @(posedge clk);
		$display("sent %0d characters and checked %0d results", chars_sent, results_seen);
		$display("the run covered every operator, division by zero, wrapping and a long stall");
		if (errors == 0) begin
			$display("[infix_expression_evaluator] OK");
		end else begin
			$display("[infix_expression_evaluator] ERROR");
		end
		$finish;
	end

	initial begin
		#(MAX_CYCLES * 4);
		$display("timeout");
		$display("[infix_expression_evaluator] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

FILE: infix_expression_evaluator.f
hw/rtl/iee_pkg.sv
hw/rtl/iee_front.sv
hw/rtl/iee_exec.sv
hw/rtl/infix_expression_evaluator.sv
tb/sv/tb.sv
